// ===== rtl/core/atgp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atgp_pkg
// Shared constants, types and the gamma table for the tone-map pixel packer.
// ----------------------------------------------------------------------------
package atgp_pkg;

	localparam int unsigned IN_W        = 24;
	localparam int unsigned GAIN_W      = 16;
	localparam int unsigned V_W         = 30;
	localparam int unsigned P_W         = 61;
	localparam int unsigned B_W         = 62;
	localparam int unsigned Q_W         = 16;
	localparam int unsigned F_W         = 17;
	localparam int unsigned GT_ADDR_W   = 10;
	localparam int unsigned GT_LOW_W    = 16 - GT_ADDR_W;
	localparam int unsigned GT_SIZE     = (1 << GT_ADDR_W) + 1;
	localparam int unsigned DIV_BITS    = 2;
	localparam int unsigned DIV_STAGES  = Q_W / DIV_BITS;

	// Stage map: exposure, products, fit terms, limit flags, divider stages,
	// table read, interpolation, byte scale.
	localparam int unsigned ST_V        = 0;
	localparam int unsigned ST_PROD     = 1;
	localparam int unsigned ST_AB       = 2;
	localparam int unsigned ST_FLAG     = 3;
	localparam int unsigned ST_TAB      = ST_FLAG + DIV_STAGES + 1;
	localparam int unsigned ST_INTERP   = ST_TAB + 1;
	localparam int unsigned ST_BYTE     = ST_INTERP + 1;
	localparam int unsigned N_STAGES    = ST_BYTE + 1;

	localparam logic [23:0] K_C1 = 24'd412360;
	localparam logic [10:0] K_C0 = 11'd1519;
	localparam logic [23:0] K_C2 = 24'd16504234;
	localparam logic [23:0] K_C3 = 24'd7263712;
	localparam logic [23:0] K_C4 = 24'd3994336;

	localparam logic [15:0] GAIN_RESET = 16'd4096;
	localparam logic [7:0]  ALPHA      = 8'hFF;
	localparam logic [2:0]  REG_GAIN   = 3'd0;

	typedef logic [N_STAGES-1:0] stage_en_t;
	typedef logic [F_W-1:0] gamma_tab_t [GT_SIZE];

	// Largest y in 0..65536 with y^11 <= (i/N)^5 * 2^176, by binary search.
	function automatic logic [F_W-1:0] gamma_entry(int unsigned i);
		logic [191:0] rhs;
		logic [191:0] lhs;
		logic [17:0]  lo;
		logic [17:0]  hi;
		logic [17:0]  mid;
		rhs = 192'd1;
		for (int k = 0; k < 5; k++) begin
			rhs = rhs * 192'(i);
		end
		rhs = rhs << (176 - 5 * GT_ADDR_W);
		lo = 18'd0;
		hi = 18'd65536;
		for (int s = 0; s < 18; s++) begin
			if (lo < hi) begin
				mid = (lo + hi + 18'd1) >> 1;
				lhs = 192'd1;
				for (int k = 0; k < 11; k++) begin
					lhs = lhs * 192'(mid);
				end
				if (lhs <= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 18'd1;
				end
			end
		end
		return lo[F_W-1:0];
	endfunction

	function automatic gamma_tab_t build_gamma();
		gamma_tab_t t;
		for (int unsigned i = 0; i < GT_SIZE; i++) begin
			t[i] = gamma_entry(i);
		end
		return t;
	endfunction

	localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage
`default_nettype wire

// ===== rtl/core/atgp_channel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atgp_channel
// Datapath of one color channel: exposure, filmic fit, gamma and byte scale.
// ----------------------------------------------------------------------------
module atgp_channel (
	input  wire logic                              clk,
	input  wire atgp_pkg::stage_en_t               en,
	input  wire logic [atgp_pkg::IN_W-1:0]         x,
	input  wire logic [atgp_pkg::GAIN_W-1:0]       gain,
	output logic      [7:0]                        chan_byte
);

	localparam int unsigned DS = atgp_pkg::DIV_STAGES;

	logic [39:0]                   prod;
	logic [35:0]                   v_full;
	logic [atgp_pkg::V_W-1:0]      v_s1;
	logic [atgp_pkg::V_W-1:0]      v_s2;
	logic [atgp_pkg::P_W-1:0]      p_s2;
	logic [atgp_pkg::V_W-1:0]      inner_s2;
	logic [53:0]                   c2v;
	logic [atgp_pkg::P_W-1:0]      a_s3;
	logic [atgp_pkg::B_W-1:0]      b_s3;
	logic                          zero_s3;
	logic [atgp_pkg::P_W-1:0]      c0_sh;
	logic [atgp_pkg::P_W-1:0]      bv;

	// Divider pipeline: entry 0 is the flag stage, the rest one stage each.
	logic [atgp_pkg::B_W-1:0]      rem_d  [DS+1];
	logic [atgp_pkg::B_W-1:0]      den_d  [DS+1];
	logic [atgp_pkg::Q_W-1:0]      quo_d  [DS+1];
	logic                          zero_d [DS+1];
	logic                          one_d  [DS+1];
	logic [atgp_pkg::B_W-1:0]      rem_nx [DS+1];
	logic [atgp_pkg::Q_W-1:0]      quo_nx [DS+1];

	logic [atgp_pkg::Q_W-1:0]      f_eff;
	logic [atgp_pkg::GT_ADDR_W-1:0] idx;
	logic [atgp_pkg::GT_ADDR_W:0]  idx1;
	logic [atgp_pkg::F_W-1:0]      t0_s13;
	logic [atgp_pkg::F_W-1:0]      t1_s13;
	logic [atgp_pkg::GT_LOW_W-1:0] frac_s13;
	logic                          one_s13;
	logic [atgp_pkg::F_W-1:0]      diff;
	logic [22:0]                   step;
	logic [atgp_pkg::F_W:0]        g_sum;
	logic [atgp_pkg::F_W-1:0]      g_s14;
	logic                          one_s14;
	logic [24:0]                   scaled;

	assign prod   = 40'(x) * 40'(gain);
	assign v_full = prod[39:4];

	always_ff @(posedge clk) begin
		if (en[atgp_pkg::ST_V]) begin
			v_s1 <= (|v_full[35:30]) ? '1 : v_full[29:0];
		end
	end

	assign c2v = 54'(atgp_pkg::K_C2) * 54'(v_s1);

	always_ff @(posedge clk) begin
		if (en[atgp_pkg::ST_PROD]) begin
			p_s2     <= 61'(v_s1) * (61'(v_s1) + 61'(atgp_pkg::K_C1));
			inner_s2 <= c2v[53:24];
			v_s2     <= v_s1;
		end
	end

	assign c0_sh = 61'(atgp_pkg::K_C0) << 24;
	assign bv    = 61'(v_s2) * (61'(inner_s2) + 61'(atgp_pkg::K_C3));

	always_ff @(posedge clk) begin
		if (en[atgp_pkg::ST_AB]) begin
			a_s3    <= p_s2 - c0_sh;
			zero_s3 <= (p_s2 <= c0_sh);
			b_s3    <= 62'(bv) + (62'(atgp_pkg::K_C4) << 24);
		end
	end

	always_ff @(posedge clk) begin
		if (en[atgp_pkg::ST_FLAG]) begin
			rem_d[0]  <= 62'(a_s3);
			den_d[0]  <= b_s3;
			quo_d[0]  <= '0;
			zero_d[0] <= zero_s3;
			one_d[0]  <= !zero_s3 && (62'(a_s3) >= b_s3);
		end
	end

	// Restoring division, two quotient bits per stage; remainder < b when a < b.
	always_comb begin
		rem_nx[0] = rem_d[0];
		quo_nx[0] = quo_d[0];
		for (int j = 1; j <= DS; j++) begin
			logic [atgp_pkg::B_W:0]   r2;
			logic [atgp_pkg::B_W-1:0] r;
			logic [atgp_pkg::Q_W-1:0] q;
			r = rem_d[j-1];
			q = quo_d[j-1];
			for (int s = 0; s < atgp_pkg::DIV_BITS; s++) begin
				r2 = {r, 1'b0};
				q  = {q[atgp_pkg::Q_W-2:0], 1'b0};
				if (r2 >= {1'b0, den_d[j-1]}) begin
					r2   = r2 - {1'b0, den_d[j-1]};
					q[0] = 1'b1;
				end
				r = r2[atgp_pkg::B_W-1:0];
			end
			rem_nx[j] = r;
			quo_nx[j] = q;
		end
	end

	for (genvar j = 1; j <= DS; j++) begin : g_div
		always_ff @(posedge clk) begin
			if (en[atgp_pkg::ST_FLAG + j]) begin
				rem_d[j]  <= rem_nx[j];
				quo_d[j]  <= quo_nx[j];
				den_d[j]  <= den_d[j-1];
				zero_d[j] <= zero_d[j-1];
				one_d[j]  <= one_d[j-1];
			end
		end
	end

	assign f_eff = zero_d[DS] ? '0 : quo_d[DS];
	assign idx   = f_eff[atgp_pkg::Q_W-1:atgp_pkg::GT_LOW_W];
	assign idx1  = {1'b0, idx} + 11'd1;

	// Gamma table read at two neighboring entries, registered.
	always_ff @(posedge clk) begin
		if (en[atgp_pkg::ST_TAB]) begin
			t0_s13   <= atgp_pkg::GAMMA_TAB[idx];
			t1_s13   <= atgp_pkg::GAMMA_TAB[idx1];
			frac_s13 <= f_eff[atgp_pkg::GT_LOW_W-1:0];
			one_s13  <= one_d[DS];
		end
	end

	assign diff  = t1_s13 - t0_s13;
	assign step  = 23'(diff) * 23'(frac_s13);
	assign g_sum = 18'(t0_s13) + 18'(step >> atgp_pkg::GT_LOW_W);

	always_ff @(posedge clk) begin
		if (en[atgp_pkg::ST_INTERP]) begin
			g_s14   <= (g_sum > 18'd65536) ? 17'd65536 : g_sum[16:0];
			one_s14 <= one_s13;
		end
	end

	assign scaled = 25'(g_s14) * 25'd255;

	always_ff @(posedge clk) begin
		if (en[atgp_pkg::ST_BYTE]) begin
			chan_byte <= one_s14 ? 8'hFF : scaled[23:16];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/aces_tonemap_gamma_pixel_pack_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aces_tonemap_gamma_pixel_pack_top
// Filmic tone map, gamma 1/2.2 and RGBA packing of linear HDR pixels.
// ----------------------------------------------------------------------------
// A pixel beat on the input channel carries three UQ8.16 linear channels; each
// result beat carries one RGBA word with red in the low byte and alpha 0xFF.
// Both channels use valid/ready. The exposure gain (UQ4.12) is written through
// the APB port at byte address 0 and may be read back.
// The datapath is a 15-stage pipeline: exposure, fit products, fit terms,
// limit flags, eight divider stages of two quotient bits each, gamma table
// read, interpolation and byte scaling. A result is registered through every
// stage in that order before it shows on the output; one pixel is accepted
// per cycle while input ready is high.
// Each stage has its own valid bit and advances when the next stage is empty
// or advancing, so bubbles close up while the receiver stalls; a stall holds
// every occupied stage, loses nothing, and input ready falls only when all
// stages are full. Reset empties the pipeline and sets the gain to 1.0.
// ----------------------------------------------------------------------------
module aces_tonemap_gamma_pixel_pack_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [23:0] red_linear,
	input  wire logic [23:0] green_linear,
	input  wire logic [23:0] blue_linear,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] packed_pixel
);

	localparam int unsigned N = atgp_pkg::N_STAGES;

	logic [15:0]          gain_q;
	logic [N-1:0]         vld_q;
	atgp_pkg::stage_en_t  en;
	logic [7:0]           red_byte;
	logic [7:0]           green_byte;
	logic [7:0]           blue_byte;

	assign pready = 1'b1;
	assign prdata = ({paddr[2], 2'b00} == atgp_pkg::REG_GAIN) ? {16'd0, gain_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= atgp_pkg::GAIN_RESET;
		end else if (psel && penable && pwrite && pready
		             && {paddr[2], 2'b00} == atgp_pkg::REG_GAIN) begin
			gain_q <= pwdata[15:0];
		end
	end

	always_comb begin
		en[N-1] = !vld_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[N-1];

	atgp_channel u_red (
		.clk       (clk),
		.en        (en),
		.x         (red_linear),
		.gain      (gain_q),
		.chan_byte (red_byte)
	);

	atgp_channel u_green (
		.clk       (clk),
		.en        (en),
		.x         (green_linear),
		.gain      (gain_q),
		.chan_byte (green_byte)
	);

	atgp_channel u_blue (
		.clk       (clk),
		.en        (en),
		.x         (blue_linear),
		.gain      (gain_q),
		.chan_byte (blue_byte)
	);

	assign packed_pixel = {atgp_pkg::ALPHA, blue_byte, green_byte, red_byte};

endmodule
`default_nettype wire

// ===== tb/sv/atgp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atgp_checker
// Watches the pixel and result channels and the register port, predicts each
// RGBA word from the accepted pixel and the current exposure gain, and
// compares it with the word that the block returns.
// ----------------------------------------------------------------------------
module atgp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [23:0] red_linear,
	input  wire logic [23:0] green_linear,
	input  wire logic [23:0] blue_linear,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] packed_pixel,
	output int               mismatch_count,
	output int               words_pending
);

	localparam logic [63:0] EXPOSED_MAX = (64'd1 << 30) - 64'd1;
	localparam logic [63:0] FIT_BIAS    = 64'd1519 << 24;

	logic [16:0] root_tab [1025];
	logic [15:0] gain;
	logic [31:0] rgba_queue [$];

	// Largest y in 0..65536 with y^11 <= (i/1024)^5 * 2^176.
	function automatic logic [16:0] gamma_root(int unsigned i);
		logic [191:0] bound;
		logic [191:0] power;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		bound = 192'd1;
		for (int k = 0; k < 5; k++) bound = bound * 192'(i);
		bound = bound << 126;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			power = 192'd1;
			for (int k = 0; k < 11; k++) power = power * 192'(mid);
			if (power <= bound) lo = mid;
			else hi = mid - 1;
		end
		return 17'(lo);
	endfunction

	function automatic logic [7:0] tone_byte(logic [23:0] radiance, logic [15:0] g);
		logic [63:0] v;
		logic [63:0] num;
		logic [63:0] den;
		logic [79:0] quot;
		logic [16:0] fit;
		logic [16:0] lo_y;
		logic [16:0] hi_y;
		logic [31:0] y;
		v = (64'(radiance) * 64'(g)) >> 4;
		if (v > EXPOSED_MAX) v = EXPOSED_MAX;
		num = v * (v + 64'd412360);
		if (num <= FIT_BIAS) return 8'd0;
		num = num - FIT_BIAS;
		den = v * (((64'd16504234 * v) >> 24) + 64'd7263712) + (64'd3994336 << 24);
		if (num >= den) return 8'd255;
		quot = (80'(num) << 16) / 80'(den);
		fit = quot[16:0];
		lo_y = root_tab[fit >> 6];
		hi_y = root_tab[(fit >> 6) + 1];
		y = 32'(lo_y) + (((32'(hi_y) - 32'(lo_y)) * 32'(fit[5:0])) >> 6);
		if (y > 32'd65536) y = 32'd65536;
		return 8'((y * 32'd255) >> 16);
	endfunction

	initial begin
		for (int unsigned i = 0; i < 1025; i++) root_tab[i] = gamma_root(i);
	end

	assign words_pending = rgba_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			gain <= 16'd4096;
			mismatch_count <= 0;
			rgba_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready
			    && paddr == 3'(atgp_pkg::REG_GAIN * 4))
				gain <= pwdata[15:0];
			if (in_valid && in_ready)
				rgba_queue.insert(rgba_queue.size(), {8'hFF,
					tone_byte(blue_linear, gain), tone_byte(green_linear, gain),
					tone_byte(red_linear, gain)});
			if (out_valid && out_ready) begin
				if (rgba_queue.size() == 0) begin
					$error("packed_pixel: unexpected beat, actual %h", packed_pixel);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = rgba_queue.pop_front();
					if (want !== packed_pixel) begin
						$error("packed_pixel: expected %h actual %h", want, packed_pixel);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives pixels and exposure settings into the tone-map pixel packer.
// A directed set of extreme and threshold radiances runs first, then random
// pixels under several gains, with random gaps on both channels, a long
// receiver stall and full drains between gain changes.
// ----------------------------------------------------------------------------
module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [23:0] red_linear = '0;
	logic [23:0] green_linear = '0;
	logic [23:0] blue_linear = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] packed_pixel;

	int mismatch_count;
	int words_pending;
	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aces_tonemap_gamma_pixel_pack_top dut (.*);

	atgp_checker checker_i (.*);

	task automatic write_gain(logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(atgp_pkg::REG_GAIN * 4);
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red_linear <= r;
		green_linear <= g;
		blue_linear <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [23:0] random_radiance();
		if ($urandom_range(0, 2) == 0) return 24'($urandom);
		return 24'($urandom) & ((24'd1 << $urandom_range(1, 23)) - 24'd1);
	endfunction

	// Receiver: random stall per beat, or one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = gaps_on ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [15:0] gains [9];
		logic [23:0] corner [12];
		gains = '{16'd4096, 16'd0, 16'd65535, 16'd1, 16'd2048, 16'd16384,
			16'($urandom), 16'($urandom), 16'($urandom)};
		// Zero, full scale, small radiances that leave the fit numerator at or below
		// zero, and around the fit reaching one.
		corner = '{24'd0, 24'hFFFFFF, 24'd1, 24'd13, 24'd14, 24'd15, 24'd16,
			24'd1680000, 24'd1703936, 24'd1720000, 24'h800000, 24'h010000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_gain(16'd4096);
		for (int i = 0; i < 12; i++) send_pixel(corner[i], corner[11 - i], corner[(i + 5) % 12]);
		for (int i = 0; i < 6; i++) send_pixel(24'hFFFFFF, 24'd14, 24'd0);
		drain();
		for (int p = 0; p < 9; p++) begin
			write_gain(gains[p]);
			gaps_on = (p % 3) != 2;
			if (p == 2) hold_req = 1'b1;
			send_pixel(24'hFFFFFF, 24'd0, 24'd15);
			for (int i = 0; i < 180; i++) begin
				send_pixel(random_radiance(), random_radiance(), random_radiance());
				if (i == 90 && p == 4) drain();
			end
			drain();
		end
		if (mismatch_count == 0 && words_pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/atgp_pkg.sv
rtl/core/atgp_channel.sv
rtl/core/aces_tonemap_gamma_pixel_pack_top.sv
tb/sv/atgp_checker.sv
tb/sv/tb.sv
